// ===== rtl/adrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrs_pkg
// Shared types, widths and the Q2.22 to PCM16 conversion for the
// downmix / resample block.
// ----------------------------------------------------------------------------
package adrs_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int PCM_W     = 16;
  localparam int CH_W      = 4;
  localparam int RATE_W    = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE    = 2'd1;

  localparam logic [CH_W-1:0]   CH_RESET   = 4'd1;
  localparam logic [CH_W-1:0]   CH_AVERAGE = 4'd2;
  localparam logic [RATE_W-1:0] RATE_RESET = 18'd16000;

  localparam logic signed [SAMPLE_W:0] UNITY_Q22     = 25'sd4194304;
  localparam logic signed [SAMPLE_W:0] NEG_UNITY_Q22 = -25'sd4194304;
  localparam logic signed [40:0]       ROUND_Q22     = 41'sd4194303;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_BYPASS = 2'd1,
    CMD_RESET  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [SAMPLE_W-1:0]  mono;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] rate;
  } rate_cfg_t;

  // clamp to +-1.0, scale by 32767, truncate toward zero
  function automatic logic signed [PCM_W-1:0] to_pcm(input logic signed [SAMPLE_W:0] v);
    logic signed [SAMPLE_W:0] c;
    logic signed [40:0]       p;
    c = v;
    if (v > UNITY_Q22) c = UNITY_Q22;
    if (v < NEG_UNITY_Q22) c = NEG_UNITY_Q22;
    p = (41'(c) <<< 15) - 41'(c);
    if (p < 0) p = p + ROUND_Q22;
    to_pcm = PCM_W'(p >>> 22);
  endfunction

endpackage

// ===== rtl/adrs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrs channel interfaces
// Frame request, PCM request and configuration write channels.
// ----------------------------------------------------------------------------
interface adrs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [adrs_pkg::SAMPLE_W-1:0] first_sample;
  logic signed [adrs_pkg::SAMPLE_W-1:0] second_sample;
  modport source (output valid, action, first_sample, second_sample, input ready);
  modport sink   (input valid, action, first_sample, second_sample, output ready);
endinterface

interface adrs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [adrs_pkg::PCM_W-1:0] pcm_sample;
  logic                              last_of_run;
  modport source (output valid, pcm_sample, last_of_run, input ready);
  modport sink   (input valid, pcm_sample, last_of_run, output ready);
endinterface

interface adrs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [adrs_pkg::CFG_IDX_W-1:0]    index;
  logic [adrs_pkg::CFG_DAT_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/adrs_step_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrs_step_div
// Reciprocal-multiply step unit: step = round(rate * 2^F / target), clamped.
// One 16-bit digit of the reciprocal is folded in per cycle.
// ----------------------------------------------------------------------------
module adrs_step_div #(
  parameter int PHASE_FRACTION_BITS = 16,
  parameter int TARGET_RATE_HZ      = 16000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  adrs_pkg::rate_cfg_t               rate_cfg,
  output logic                              busy,
  output logic [PHASE_FRACTION_BITS+3:0]    step
);
  localparam int F   = PHASE_FRACTION_BITS;
  localparam int NW  = adrs_pkg::RATE_W + F + 1;   // numerator width
  localparam int TW  = $clog2(TARGET_RATE_HZ);
  localparam int SH  = NW + TW;                    // reciprocal scale, exact below 2^NW
  localparam int DW  = 16;                         // reciprocal digit per cycle
  localparam int NCH = (NW + 2 + DW - 1) / DW;     // digits in the reciprocal
  localparam int MW  = NCH * DW;
  localparam int PW  = NW + MW;                    // full product width
  localparam int QW  = PW - SH;
  localparam int CW  = $clog2(NCH + 1);
  localparam logic [63:0]   RECIP_FULL = ((64'd1 << SH) + 64'(TARGET_RATE_HZ - 1))
                                         / 64'(TARGET_RATE_HZ);
  localparam logic [MW-1:0] RECIP   = MW'(RECIP_FULL);
  localparam logic [NW-1:0] HALF_T  = NW'(TARGET_RATE_HZ / 2);
  localparam logic [QW-1:0] Q_HALF  = QW'(1) << (F - 1);
  localparam logic [QW-1:0] Q_MAX   = (QW'(1) << (F + 4)) - QW'(1);

  logic             pending, running, fin;
  logic [CW-1:0]    cnt;
  logic [NW-1:0]    num;
  logic [MW-1:0]    digits;
  logic [PW-1:0]    acc;
  logic [NW+DW-1:0] part;
  logic [QW-1:0]    quo;

  assign busy = pending | running | fin;
  assign part = (NW+DW)'(num) * (NW+DW)'(digits[MW-1 -: DW]);
  assign quo  = acc[PW-1:SH];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b1;
      running <= 1'b0;
      fin     <= 1'b0;
      cnt     <= '0;
    end else if (rate_cfg.start) begin
      pending <= 1'b1;
      running <= 1'b0;
      fin     <= 1'b0;
    end else if (pending) begin
      pending <= 1'b0;
      running <= 1'b1;
      cnt     <= CW'(NCH);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        running <= 1'b0;
        fin     <= 1'b1;
      end
    end else if (fin) begin
      fin <= 1'b0;
    end
  end

  // Horner over the reciprocal digits, top digit first
  always_ff @(posedge clk) begin
    if (pending) begin
      num    <= NW'({rate_cfg.rate, {F{1'b0}}}) + HALF_T;
      digits <= RECIP;
      acc    <= '0;
    end else if (running) begin
      digits <= {digits[MW-DW-1:0], {DW{1'b0}}};
      acc    <= {acc[PW-DW-1:0], {DW{1'b0}}} + PW'(part);
    end
    if (fin) begin
      if (quo < Q_HALF)      step <= Q_HALF[F+3:0];
      else if (quo > Q_MAX)  step <= Q_MAX[F+3:0];
      else                   step <= quo[F+3:0];
    end
  end

endmodule

// ===== rtl/adrs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrs_front
// Config registers, frame intake, mono downmix and command classification.
// ----------------------------------------------------------------------------
module adrs_front #(
  parameter int TARGET_RATE_HZ = 16000
) (
  input  logic                 clk,
  input  logic                 rst,
  adrs_cfg_if.sink             cfg,
  adrs_in_if.sink              frame,
  input  logic                 step_busy,
  input  logic                 q_full,
  output logic                 q_push,
  output adrs_pkg::cmd_t       q_cmd,
  output adrs_pkg::rate_cfg_t  rate_cfg
);
  logic [adrs_pkg::CH_W-1:0]   channel_count;
  logic [adrs_pkg::RATE_W-1:0] input_rate_hz;
  logic signed [adrs_pkg::SAMPLE_W:0] pair_sum;
  logic                        bypass;
  logic                        cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= adrs_pkg::CH_RESET;
      input_rate_hz <= adrs_pkg::RATE_RESET;
    end else if (cfg_wr) begin
      case (cfg.index)
        adrs_pkg::REG_CHANNEL_COUNT: channel_count <= cfg.data[adrs_pkg::CH_W-1:0];
        adrs_pkg::REG_INPUT_RATE:    input_rate_hz <= cfg.data[adrs_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // a new rate restarts the step divider, which holds off frames until done
  assign rate_cfg.start = cfg_wr && (cfg.index == adrs_pkg::REG_INPUT_RATE);
  assign rate_cfg.rate  = input_rate_hz;

  assign frame.ready = !q_full && !step_busy && !cfg.valid;
  assign q_push      = frame.valid && frame.ready;

  assign pair_sum = (adrs_pkg::SAMPLE_W+1)'(frame.first_sample)
                  + (adrs_pkg::SAMPLE_W+1)'(frame.second_sample);
  assign bypass   = (input_rate_hz == '0)
                 || (input_rate_hz == adrs_pkg::RATE_W'(TARGET_RATE_HZ));

  always_comb begin
    if (channel_count == adrs_pkg::CH_AVERAGE)
      q_cmd.mono = adrs_pkg::SAMPLE_W'(pair_sum >>> 1);
    else
      q_cmd.mono = frame.first_sample;
    if (frame.action)  q_cmd.kind = adrs_pkg::CMD_RESET;
    else if (bypass)   q_cmd.kind = adrs_pkg::CMD_BYPASS;
    else               q_cmd.kind = adrs_pkg::CMD_SAMPLE;
  end

endmodule

// ===== rtl/adrs_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrs_cmd_fifo
// Two-entry command queue between the front and back halves.
// ----------------------------------------------------------------------------
module adrs_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  adrs_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output adrs_pkg::cmd_t  head
);
  adrs_pkg::cmd_t entry [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  logic           do_push, do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign head    = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_cmd;
  end

endmodule

// ===== rtl/adrs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adrs_back
// Resampler state, interpolation sequencer and PCM output register.
// ----------------------------------------------------------------------------
module adrs_back #(
  parameter int PHASE_FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  adrs_pkg::cmd_t                 q_head,
  output logic                           q_pop,
  input  logic [PHASE_FRACTION_BITS+3:0] step,
  adrs_out_if.source                     pcm
);
  localparam int F  = PHASE_FRACTION_BITS;
  localparam int SW = adrs_pkg::SAMPLE_W;
  localparam int PW = SW + F + 2;
  localparam logic [F+4:0] PHASE_ONE = (F+5)'(1) << F;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_CONV = 3'b100
  } state_t;

  state_t                 state;
  logic signed [SW-1:0]   previous;
  logic                   have_previous;
  logic [F+3:0]           phase;
  logic signed [SW-1:0]   cur_mono;
  logic                   is_bypass;
  logic                   second;
  logic [F+4:0]           pos;
  logic signed [PW-1:0]   prod;
  logic signed [SW:0]     diff;
  logic signed [SW:0]     value;
  logic [F+4:0]           pos_next;
  logic [F+4:0]           phase_sub;
  logic                   more;
  logic                   out_free;
  logic                   out_load;

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign diff      = (SW+1)'(cur_mono) - (SW+1)'(previous);
  assign pos_next  = pos + (F+5)'(step);
  assign phase_sub = pos_next - PHASE_ONE;
  assign more      = !is_bypass && !second && (pos_next < PHASE_ONE);
  assign out_free  = !pcm.valid || pcm.ready;
  assign out_load  = (state == ST_CONV) && out_free;
  assign value     = is_bypass ? (SW+1)'(cur_mono)
                               : (SW+1)'(previous) + (SW+1)'(prod >>> F);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      previous      <= '0;
      have_previous <= 1'b0;
      phase         <= '0;
      pcm.valid     <= 1'b0;
    end else begin
      if (out_load)       pcm.valid <= 1'b1;
      else if (pcm.ready) pcm.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            case (q_head.kind)
              adrs_pkg::CMD_RESET: begin
                previous      <= '0;
                have_previous <= 1'b0;
                phase         <= '0;
              end
              adrs_pkg::CMD_BYPASS: begin
                state <= ST_CONV;
              end
              adrs_pkg::CMD_SAMPLE: begin
                if (!have_previous) begin
                  previous      <= q_head.mono;
                  have_previous <= 1'b1;
                end else if ({1'b0, phase} >= PHASE_ONE) begin
                  // phase already past this interval: no output
                  phase    <= phase - PHASE_ONE[F+3:0];
                  previous <= q_head.mono;
                end else begin
                  state <= ST_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_CONV;
        end
        ST_CONV: begin
          if (out_free) begin
            if (more) begin
              state <= ST_MUL;
            end else begin
              state <= ST_IDLE;
              if (!is_bypass) begin
                phase    <= (pos_next >= PHASE_ONE) ? phase_sub[F+3:0] : '0;
                previous <= cur_mono;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !q_empty) begin
      cur_mono  <= q_head.mono;
      is_bypass <= q_head.kind == adrs_pkg::CMD_BYPASS;
      second    <= 1'b0;
      pos       <= {1'b0, phase};
    end
    if (state == ST_MUL) begin
      prod <= diff * $signed({1'b0, pos[F-1:0]});
    end
    if (state == ST_CONV && out_free) begin
      pcm.pcm_sample  <= adrs_pkg::to_pcm(value);
      pcm.last_of_run <= !more;
      if (more) begin
        second <= 1'b1;
        pos    <= pos_next;
      end
    end
  end

endmodule

// ===== rtl/audio_downmix_resample_pcm16_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_downmix_resample_pcm16_top
// Mono downmix, linear-interpolation resampler to TARGET_RATE_HZ, PCM16 out.
// ----------------------------------------------------------------------------
// Usage:
//  - frame: one request per capture frame (action 0) or a resampler clear
//    (action 1). Accepted when valid and ready are both high.
//  - pcm: zero, one or two PCM16 requests per frame; last_of_run marks the
//    final one of each frame. Held in an output register until taken.
//  - cfg: register writes, index 0 = channel_count, 1 = input_rate_hz.
//    Always ready. A rate write restarts the step unit, which holds frame.ready
//    low while it loads the rate, folds in the reciprocal digits and clamps.
// Flow:
//  - The front half takes a frame per cycle into a two-entry queue while
//    the queue has room, the step unit is idle and no cfg write is pending.
//  - The back half pops a command only in its idle state. A clear or a
//    first or skipped sample ends there, a bypassed sample is then converted,
//    and each interpolated output (one or two per frame) takes a multiply,
//    then a convert. The interpolation multiply and the PCM conversion set
//    the back-end cost of a frame; no new frame is popped until idle again.
// Reset (rst, synchronous): clears the resampler state, loads channel_count
//  1 and input_rate_hz 16000, and runs the step unit once.
// Stall: a held pcm request stops the back half; the queue then fills and
//  frame.ready drops. Nothing is dropped.
// ----------------------------------------------------------------------------
module audio_downmix_resample_pcm16_top #(
  parameter int PHASE_FRACTION_BITS = 16,
  parameter int TARGET_RATE_HZ      = 16000
) (
  input  logic       clk,
  input  logic       rst,
  adrs_cfg_if.sink   cfg,
  adrs_in_if.sink    frame,
  adrs_out_if.source pcm
);
  adrs_pkg::cmd_t                 push_cmd;
  adrs_pkg::cmd_t                 head;
  adrs_pkg::rate_cfg_t            rate_cfg;
  logic                           push, full, pop, empty;
  logic                           step_busy;
  logic [PHASE_FRACTION_BITS+3:0] step;

  // front half: config registers, downmix, classification
  adrs_front #(
    .TARGET_RATE_HZ (TARGET_RATE_HZ)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .frame     (frame),
    .step_busy (step_busy),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd),
    .rate_cfg  (rate_cfg)
  );

  // phase step from the capture rate, recomputed on every rate write
  adrs_step_div #(
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS),
    .TARGET_RATE_HZ      (TARGET_RATE_HZ)
  ) u_step (
    .clk      (clk),
    .rst      (rst),
    .rate_cfg (rate_cfg),
    .busy     (step_busy),
    .step     (step)
  );

  // decouples intake from the output-bound back half
  adrs_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  // back half: interpolation and PCM output
  adrs_back #(
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (empty),
    .q_head  (head),
    .q_pop   (pop),
    .step    (step),
    .pcm     (pcm)
  );

endmodule
